// File: rtl/servo_position_pid_drive_top_defines.svh
// Assertion macros shared by the servo drive RTL.
`ifndef SERVO_POSITION_PID_DRIVE_TOP_DEFINES_SVH
`define SERVO_POSITION_PID_DRIVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo drive check failed");

// Next-cycle implication, disabled during reset.
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo drive check failed");

`endif

// File: rtl/spd_pkg.sv
`timescale 1ns / 1ps

package spd_pkg;

  localparam int NUM_SAMPLES = 10;
  localparam int SAMPLE_W    = 12;
  localparam int GOAL_W      = 16;
  localparam int RANK_W      = $clog2(NUM_SAMPLES);
  localparam int MID_LO      = (NUM_SAMPLES - 1) / 2;
  localparam int MID_HI      = NUM_SAMPLES / 2;

  // Stream payload layout
  localparam int IN_DATA_W   = 136;
  localparam int GOAL_LSB    = 120;
  localparam int OUT_DATA_W  = 40;
  localparam int DRIVE_W     = 13;

  // Configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_ZONE  = 3'd7;

  localparam logic [7:0]  GAIN_P_RESET        = 8'd6;
  localparam logic [7:0]  GAIN_I_RESET        = 8'd0;
  localparam logic [7:0]  GAIN_D_RESET        = 8'd0;
  localparam logic [11:0] LOWER_LIMIT_RESET   = 12'd200;
  localparam logic [11:0] UPPER_LIMIT_RESET   = 12'd4000;
  localparam logic [11:0] DRIVE_CEILING_RESET = 12'd3500;
  localparam logic [11:0] DRIVE_FLOOR_RESET   = 12'd10;
  localparam logic [11:0] ARRIVAL_ZONE_RESET  = 12'd1;

  localparam int SUM_LIMIT = 500;
  localparam logic [SAMPLE_W-1:0] TARGET_RESET = 12'd2000;

  typedef logic [NUM_SAMPLES-1:0][SAMPLE_W-1:0] sample_arr_t;
  typedef logic [NUM_SAMPLES-1:0][RANK_W-1:0]   rank_arr_t;

  typedef struct packed {
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
    logic [7:0]  gain_d;
    logic [11:0] lower_limit;
    logic [11:0] upper_limit;
    logic [11:0] drive_ceiling;
    logic [11:0] drive_floor;
    logic [11:0] arrival_zone;
  } cfg_t;

endpackage

// File: rtl/spd_rank_lane.sv
`timescale 1ns / 1ps

module spd_rank_lane
  import spd_pkg::*;
(
  input  sample_arr_t       samples,
  input  logic [RANK_W-1:0] lane_id,
  output logic [RANK_W-1:0] rank
);

  logic [SAMPLE_W-1:0] own;

  // Rank = samples below this one, ties broken by lane order, so every
  // lane ends up with a distinct rank.
  always_comb begin
    own  = samples[lane_id];
    rank = '0;
    for (int j = 0; j < NUM_SAMPLES; j++) begin
      if ((samples[j] < own) ||
          ((samples[j] == own) && (RANK_W'(j) < lane_id))) begin
        rank = rank + RANK_W'(1);
      end
    end
  end

endmodule

// File: rtl/spd_median_merge.sv
`timescale 1ns / 1ps

module spd_median_merge
  import spd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sample_arr_t         samples,
  input  rank_arr_t           ranks,
  input  logic [GOAL_W-1:0]   goal_in,
  input  logic                req_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] pos,
  output logic [GOAL_W-1:0]   goal_out,
  output logic                req_out
);

  logic [SAMPLE_W-1:0] mid_lo;
  logic [SAMPLE_W-1:0] mid_hi;
  logic [SAMPLE_W:0]   mid_sum;

  // Exactly one lane holds each rank: OR-select the two middle samples.
  always_comb begin
    mid_lo = '0;
    mid_hi = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      if (ranks[i] == RANK_W'(MID_LO)) mid_lo = mid_lo | samples[i];
      if (ranks[i] == RANK_W'(MID_HI)) mid_hi = mid_hi | samples[i];
    end
    mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pos      <= mid_sum[SAMPLE_W:1];
      goal_out <= goal_in;
      req_out  <= req_in;
    end
  end

endmodule

// File: rtl/spd_pid_core.sv
`timescale 1ns / 1ps
`include "servo_position_pid_drive_top_defines.svh"

module spd_pid_core
  import spd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   pos,
  input  logic [GOAL_W-1:0]     goal_in,
  input  logic                  req_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [DRIVE_W-1:0] out_drive,
  output logic [SAMPLE_W-1:0]   out_pos,
  output logic [SAMPLE_W-1:0]   out_goal,
  output logic                  out_en,
  output logic                  out_act
);

  localparam logic signed [13:0] SUM_HI = 14'(SUM_LIMIT);
  localparam logic signed [13:0] SUM_LO = -14'(SUM_LIMIT);

  // Loop state
  logic [SAMPLE_W-1:0]      last_target;
  logic signed [12:0]       previous_error;
  logic signed [9:0]        error_sum;
  logic                     active_flag;

  // Control stage
  logic                     neq;
  logic                     c_en;
  logic                     hold;
  logic [GOAL_W-1:0]        g_hold;
  logic [GOAL_W-1:0]        g_lo;
  logic [SAMPLE_W-1:0]      g_cl;
  logic signed [12:0]       c_err;
  logic signed [13:0]       sum_raw;
  logic signed [9:0]        sum_c;
  logic signed [13:0]       c_diff;

  logic                     v3, v4;
  logic                     ready3, ready4, ready5;

  logic signed [12:0]       s3_err;
  logic signed [9:0]        s3_sum;
  logic signed [13:0]       s3_diff;
  logic [SAMPLE_W-1:0]      s3_pos;
  logic [SAMPLE_W-1:0]      s3_goal;
  logic                     s3_en;
  logic                     s3_act;

  logic signed [21:0]       s4_pp;
  logic signed [18:0]       s4_pi;
  logic signed [22:0]       s4_pd;
  logic                     s4_gate;
  logic [SAMPLE_W-1:0]      s4_pos;
  logic [SAMPLE_W-1:0]      s4_goal;
  logic                     s4_en;
  logic                     s4_act;

  logic [12:0]              err_mag;
  logic                     gate;
  logic signed [24:0]       pid_sum;
  logic signed [24:0]       pid_db;
  logic signed [24:0]       floor_s;
  logic signed [24:0]       ceil_s;
  logic signed [24:0]       pid_sat;

  assign ready5   = !out_valid || out_ready;
  assign ready4   = !v4 || ready5;
  assign ready3   = !v3 || ready4;
  assign in_ready = ready3;

  always_comb begin
    neq     = goal_in != {4'b0, last_target};
    c_en    = req_in || neq;
    // Enabling from idle with an unchanged goal holds the present position
    hold    = c_en && !active_flag && !neq;
    g_hold  = hold ? {4'b0, pos} : goal_in;
    g_lo    = (g_hold < {4'b0, cfg.lower_limit}) ? {4'b0, cfg.lower_limit} : g_hold;
    g_cl    = (g_lo > {4'b0, cfg.upper_limit}) ? cfg.upper_limit : g_lo[SAMPLE_W-1:0];
    c_err   = $signed({1'b0, pos}) - $signed({1'b0, g_cl});
    sum_raw = {{4{error_sum[9]}}, error_sum} + {c_err[12], c_err};
    if (sum_raw > SUM_HI) begin
      sum_c = SUM_HI[9:0];
    end else if (sum_raw < SUM_LO) begin
      sum_c = SUM_LO[9:0];
    end else begin
      sum_c = sum_raw[9:0];
    end
    c_diff  = {c_err[12], c_err} - {previous_error[12], previous_error};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_target    <= TARGET_RESET;
      previous_error <= '0;
      error_sum      <= '0;
      active_flag    <= 1'b0;
      v3             <= 1'b0;
    end else begin
      if (ready3) v3 <= in_valid;
      if (ready3 && in_valid) begin
        last_target    <= g_cl;
        previous_error <= c_err;
        error_sum      <= sum_c;
        active_flag    <= c_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) begin
      s3_err  <= c_err;
      s3_sum  <= sum_c;
      s3_diff <= c_diff;
      s3_pos  <= pos;
      s3_goal <= g_cl;
      s3_en   <= c_en;
      s3_act  <= c_en;
    end
  end

  // Multiply stage and drive gating
  always_comb begin
    err_mag = s3_err[12] ? 13'(-s3_err) : 13'(s3_err);
    gate = !s3_act || (err_mag < {1'b0, cfg.arrival_zone}) ||
           (s3_pos > cfg.upper_limit) || (s3_pos < cfg.lower_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      s4_pp   <= $signed({1'b0, cfg.gain_p}) * s3_err;
      s4_pi   <= $signed({1'b0, cfg.gain_i}) * s3_sum;
      s4_pd   <= $signed({1'b0, cfg.gain_d}) * s3_diff;
      s4_gate <= gate;
      s4_pos  <= s3_pos;
      s4_goal <= s3_goal;
      s4_en   <= s3_en;
      s4_act  <= s3_act;
    end
  end

  // Sum, dead band, saturation
  always_comb begin
    floor_s = $signed({13'b0, cfg.drive_floor});
    ceil_s  = $signed({13'b0, cfg.drive_ceiling});
    pid_sum = 25'(s4_pp) + 25'(s4_pi) + 25'(s4_pd);
    if (s4_gate || ((pid_sum < floor_s) && (pid_sum > -floor_s))) begin
      pid_db = '0;
    end else begin
      pid_db = pid_sum;
    end
    if (pid_db > ceil_s) begin
      pid_sat = ceil_s;
    end else if (pid_db < -ceil_s) begin
      pid_sat = -ceil_s;
    end else begin
      pid_sat = pid_db;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      out_drive <= pid_sat[DRIVE_W-1:0];
      out_pos   <= s4_pos;
      out_goal  <= s4_goal;
      out_en    <= s4_en;
      out_act   <= s4_act;
    end
  end

  `SPD_ASSERT_NEXT(a_active_follows_enable, clk, rst, in_valid && in_ready, active_flag == $past(c_en))
  `SPD_ASSERT_IMP(a_sum_bounded, clk, rst, 1'b1, (error_sum <= 10'sd500) && (error_sum >= -10'sd500))
  `SPD_ASSERT_IMP(a_goal_under_upper, clk, rst, v3, s3_goal <= cfg.upper_limit)
  `SPD_ASSERT_IMP(a_drive_needs_active, clk, rst, out_valid && (out_drive != '0), out_act)
  `SPD_ASSERT_IMP(a_drive_in_ceiling, clk, rst, out_valid, (out_drive <= $signed({1'b0, cfg.drive_ceiling})) && (out_drive >= -$signed({1'b0, cfg.drive_ceiling})))

endmodule

// File: rtl/servo_position_pid_drive_top.sv
`timescale 1ns / 1ps
// Position servo PID drive, one control tick per transfer.
// Input stream (s_*): one transfer carries the position ADC samples and the
// host goal in s_tdata, and the host torque-enable bit in s_tuser.
// Output stream (m_*): one transfer per input transfer with the signed drive,
// the median position and the goal written back in m_tdata, and the torque
// enable and engaged flags in m_tuser.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; write only while no tick is in flight.
// Throughput: one transfer per cycle while m_tready is not held off. Five
// register stages: lane ranking, median merge, loop control, gain multipliers,
// and sum and limit.
// The loop control stage closes target, error and integral combinationally and
// registers them as a tick is taken, which lets consecutive ticks follow back to back.
// Reset (rst, synchronous) loads the default gains and limits, sets the stored
// target to 2000, clears the error history and drops torque.
// When the receiver holds off m_tready the result stays on m_tdata and the
// pipeline keeps filling its empty stages; s_tready falls once all are full.
module servo_position_pid_drive_top
  import spd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: sample_0 .. sample_9 (12 bit each), goal_position (16 bit)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: torque_request
  input  logic                  s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // m_tdata: drive (13 bit signed), present_position (12), goal_written_back
  // (12), zero pad (3)
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: torque_enable_out, torque_active
  output logic [1:0]            m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg;
  sample_arr_t         in_samples;
  rank_arr_t           lane_rank;

  logic                v1;
  sample_arr_t         s1_samples;
  rank_arr_t           s1_ranks;
  logic [GOAL_W-1:0]   s1_goal;
  logic                s1_req;
  logic                merge_ready;

  logic                v2;
  logic                core_ready;
  logic [SAMPLE_W-1:0] s2_pos;
  logic [GOAL_W-1:0]   s2_goal;
  logic                s2_req;

  logic signed [DRIVE_W-1:0] drive;
  logic [SAMPLE_W-1:0] present_position;
  logic [SAMPLE_W-1:0] goal_written_back;
  logic                torque_enable_out;
  logic                torque_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p        <= GAIN_P_RESET;
      cfg.gain_i        <= GAIN_I_RESET;
      cfg.gain_d        <= GAIN_D_RESET;
      cfg.lower_limit   <= LOWER_LIMIT_RESET;
      cfg.upper_limit   <= UPPER_LIMIT_RESET;
      cfg.drive_ceiling <= DRIVE_CEILING_RESET;
      cfg.drive_floor   <= DRIVE_FLOOR_RESET;
      cfg.arrival_zone  <= ARRIVAL_ZONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:        cfg.gain_p        <= cfg_data[7:0];
        REG_GAIN_I:        cfg.gain_i        <= cfg_data[7:0];
        REG_GAIN_D:        cfg.gain_d        <= cfg_data[7:0];
        REG_LOWER_LIMIT:   cfg.lower_limit   <= cfg_data;
        REG_UPPER_LIMIT:   cfg.upper_limit   <= cfg_data;
        REG_DRIVE_CEILING: cfg.drive_ceiling <= cfg_data;
        REG_DRIVE_FLOOR:   cfg.drive_floor   <= cfg_data;
        REG_ARRIVAL_ZONE:  cfg.arrival_zone  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      in_samples[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
    end
  end

  for (genvar g = 0; g < NUM_SAMPLES; g++) begin : g_lane
    spd_rank_lane u_lane (
      .samples (in_samples),
      .lane_id (RANK_W'(g)),
      .rank    (lane_rank[g])
    );
  end

  assign s_tready = !v1 || merge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_samples <= in_samples;
      s1_ranks   <= lane_rank;
      s1_goal    <= s_tdata[GOAL_LSB +: GOAL_W];
      s1_req     <= s_tuser;
    end
  end

  spd_median_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (merge_ready),
    .samples   (s1_samples),
    .ranks     (s1_ranks),
    .goal_in   (s1_goal),
    .req_in    (s1_req),
    .out_valid (v2),
    .out_ready (core_ready),
    .pos       (s2_pos),
    .goal_out  (s2_goal),
    .req_out   (s2_req)
  );

  spd_pid_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (v2),
    .in_ready  (core_ready),
    .pos       (s2_pos),
    .goal_in   (s2_goal),
    .req_in    (s2_req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_drive (drive),
    .out_pos   (present_position),
    .out_goal  (goal_written_back),
    .out_en    (torque_enable_out),
    .out_act   (torque_active)
  );

  assign m_tdata = {3'b0, goal_written_back, present_position, drive};
  assign m_tuser = {torque_active, torque_enable_out};

endmodule

// File: bench/servo_drive_monitor.sv
`timescale 1ns / 1ps

module servo_drive_monitor
  import spd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [1:0]            m_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    ticks_in_flight,
  output logic [SAMPLE_W-1:0]   target_now
);

  localparam int POS_LSB      = DRIVE_W;
  localparam int WB_LSB       = DRIVE_W + SAMPLE_W;
  localparam int PAD_LSB      = DRIVE_W + 2 * SAMPLE_W;
  localparam int PAD_W        = OUT_DATA_W - PAD_LSB;
  localparam int REPORT_LINES = 50;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic [SAMPLE_W-1:0]       position;
    logic [SAMPLE_W-1:0]       goal;
    logic                      torque_on;
    logic                      engaged;
  } tick_result_t;

  cfg_t                settings;
  logic [SAMPLE_W-1:0] target;
  int                  last_error;
  int                  error_sum;
  logic                engaged;
  tick_result_t        expected_ticks[$];
  tick_result_t        want;
  tick_result_t        got_tick;
  int                  fails = 0;

  task automatic report_mismatch(input string msg);
    if (fails < REPORT_LINES) $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(input string field, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s mismatch: got %0d, want %0d", field, got, exp_val));
  endtask

  function automatic int median_position(input logic [IN_DATA_W-1:0] data);
    int v[NUM_SAMPLES];
    int i, j, t;
    for (i = 0; i < NUM_SAMPLES; i++) v[i] = int'(data[SAMPLE_W*i +: SAMPLE_W]);
    for (j = 0; j < NUM_SAMPLES - 1; j++) begin
      for (i = 0; i < NUM_SAMPLES - j - 1; i++) begin
        if (v[i] > v[i+1]) begin
          t = v[i];
          v[i] = v[i+1];
          v[i+1] = t;
        end
      end
    end
    if (NUM_SAMPLES % 2 == 1) return v[MID_LO];
    return (v[MID_LO] + v[MID_HI]) / 2;
  endfunction

  // One control tick: target update, error history and gated PID drive.
  task automatic run_tick(input logic [IN_DATA_W-1:0] data, input logic torque,
                          output tick_result_t r);
    int   pos, goal, err, diff, sum, pid, err_mag;
    int   lo, hi, ceil_mag, floor_mag, zone;
    logic on;
    lo        = int'(settings.lower_limit);
    hi        = int'(settings.upper_limit);
    ceil_mag  = int'(settings.drive_ceiling);
    floor_mag = int'(settings.drive_floor);
    zone      = int'(settings.arrival_zone);
    pos       = median_position(data);
    goal      = int'(data[GOAL_LSB +: GOAL_W]);
    on        = torque;
    if (goal != int'(target)) on = 1'b1;
    if (!on) engaged = 1'b0;
    if (!engaged && on) begin
      // enabling from idle with an unchanged goal holds the present position
      if (goal == int'(target)) goal = pos;
      engaged = 1'b1;
    end
    if (goal < lo) goal = lo;
    if (goal > hi) goal = hi;
    target = goal[SAMPLE_W-1:0];

    err = pos - goal;
    sum = error_sum + err;
    if (sum > SUM_LIMIT) sum = SUM_LIMIT;
    if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
    error_sum  = sum;
    diff       = err - last_error;
    last_error = err;

    pid = int'(settings.gain_p) * err + int'(settings.gain_i) * sum
        + int'(settings.gain_d) * diff;
    err_mag = (err < 0) ? -err : err;
    if (!engaged || err_mag < zone || pos > hi || pos < lo) pid = 0;
    if (pid < floor_mag && pid > -floor_mag) pid = 0;
    if (pid > ceil_mag) pid = ceil_mag;
    if (pid < -ceil_mag) pid = -ceil_mag;

    r.drive     = pid[DRIVE_W-1:0];
    r.position  = pos[SAMPLE_W-1:0];
    r.goal      = goal[SAMPLE_W-1:0];
    r.torque_on = on;
    r.engaged   = engaged;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      settings = '{gain_p: GAIN_P_RESET, gain_i: GAIN_I_RESET, gain_d: GAIN_D_RESET,
                   lower_limit: LOWER_LIMIT_RESET, upper_limit: UPPER_LIMIT_RESET,
                   drive_ceiling: DRIVE_CEILING_RESET, drive_floor: DRIVE_FLOOR_RESET,
                   arrival_zone: ARRIVAL_ZONE_RESET};
      target     = TARGET_RESET;
      last_error = 0;
      error_sum  = 0;
      engaged    = 1'b0;
      expected_ticks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P:        settings.gain_p        = cfg_data[7:0];
          REG_GAIN_I:        settings.gain_i        = cfg_data[7:0];
          REG_GAIN_D:        settings.gain_d        = cfg_data[7:0];
          REG_LOWER_LIMIT:   settings.lower_limit   = cfg_data;
          REG_UPPER_LIMIT:   settings.upper_limit   = cfg_data;
          REG_DRIVE_CEILING: settings.drive_ceiling = cfg_data;
          REG_DRIVE_FLOOR:   settings.drive_floor   = cfg_data;
          REG_ARRIVAL_ZONE:  settings.arrival_zone  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        run_tick(s_tdata, s_tuser, want);
        expected_ticks.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch("result transfer with no tick outstanding");
        end else begin
          got_tick = expected_ticks.pop_front();
          check_field("drive", int'($signed(m_tdata[DRIVE_W-1:0])), int'(got_tick.drive));
          check_field("present_position", int'(m_tdata[POS_LSB +: SAMPLE_W]),
                      int'(got_tick.position));
          check_field("goal_written_back", int'(m_tdata[WB_LSB +: SAMPLE_W]),
                      int'(got_tick.goal));
          check_field("pad", int'(m_tdata[PAD_LSB +: PAD_W]), 0);
          check_field("torque_enable_out", int'(m_tuser[0]), int'(got_tick.torque_on));
          check_field("torque_active", int'(m_tuser[1]), int'(got_tick.engaged));
        end
      end
    end
    fail_count      <= fails;
    ticks_in_flight <= expected_ticks.size();
    target_now      <= target;
  end

endmodule

// File: bench/tb_servo_position_pid_drive_top.sv
`timescale 1ns / 1ps

module tb_servo_position_pid_drive_top;
  import spd_pkg::*;

  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 155;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                  fail_count;
  int                  ticks_in_flight;
  logic [SAMPLE_W-1:0] target_now;
  bit                  calm = 1'b0;

  always #5 clk = ~clk;

  servo_position_pid_drive_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  servo_drive_monitor u_monitor (
    .clk             (clk),
    .rst             (rst),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .ticks_in_flight (ticks_in_flight),
    .target_now      (target_now)
  );

  // Receiver stalls at random unless in the calm stretch.
  always @(negedge clk) m_tready = calm || ($urandom_range(99) >= 29);

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_tick(input logic [IN_DATA_W-1:0] data, input logic torque);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_tdata  = data;
    s_tuser  = torque;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (ticks_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_GAIN_P, int'(c.gain_p));
    write_reg(REG_GAIN_I, int'(c.gain_i));
    write_reg(REG_GAIN_D, int'(c.gain_d));
    write_reg(REG_LOWER_LIMIT, int'(c.lower_limit));
    write_reg(REG_UPPER_LIMIT, int'(c.upper_limit));
    write_reg(REG_DRIVE_CEILING, int'(c.drive_ceiling));
    write_reg(REG_DRIVE_FLOOR, int'(c.drive_floor));
    write_reg(REG_ARRIVAL_ZONE, int'(c.arrival_zone));
    cfg_we = 1'b0;
  endtask

  function automatic logic [IN_DATA_W-1:0] flat_tick(input int pos, input int goal);
    logic [IN_DATA_W-1:0] d;
    int i;
    d = '0;
    for (i = 0; i < NUM_SAMPLES; i++) d[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(pos);
    d[GOAL_LSB +: GOAL_W] = GOAL_W'(goal);
    return d;
  endfunction

  // Mostly well-formed tracking of the held target with samples clustered
  // around a position; the rest new goals, releases and bit noise.
  task automatic random_tick(output logic [IN_DATA_W-1:0] data, output logic torque);
    int base, spread, pick, s, i;
    logic [GOAL_W-1:0] goal;
    data = '0;
    pick = $urandom_range(99);
    base = (pick < 40) ? int'(target_now) + int'($urandom_range(60)) - 30
                       : int'($urandom_range(4095));
    pick = $urandom_range(99);
    spread = (pick < 60) ? int'($urandom_range(8)) :
             (pick < 85) ? int'($urandom_range(200)) : -1;
    for (i = 0; i < NUM_SAMPLES; i++) begin
      if (spread < 0) s = $urandom_range(4095);
      else s = base + int'($urandom_range(2 * spread)) - spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      data[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(s);
    end
    pick = $urandom_range(99);
    torque = 1'($urandom_range(1));
    if (pick < 55) begin
      goal   = GOAL_W'(target_now);
      torque = 1'b1;
    end else if (pick < 65) begin
      goal   = GOAL_W'(target_now);
      torque = 1'b0;
    end else if (pick < 80) begin
      goal = GOAL_W'($urandom_range(4095));
    end else if (pick < 90) begin
      goal = GOAL_W'($urandom_range(65535));
    end else begin
      goal = GOAL_W'(target_now) ^ (16'h0001 << $urandom_range(15));
    end
    data[GOAL_LSB +: GOAL_W] = goal;
  endtask

  function automatic cfg_t make_settings(input int p, input int i, input int d,
                                         input int lo, input int hi, input int ceil_mag,
                                         input int floor_mag, input int zone);
    cfg_t c;
    c.gain_p        = 8'(p);
    c.gain_i        = 8'(i);
    c.gain_d        = 8'(d);
    c.lower_limit   = 12'(lo);
    c.upper_limit   = 12'(hi);
    c.drive_ceiling = 12'(ceil_mag);
    c.drive_floor   = 12'(floor_mag);
    c.arrival_zone  = 12'(zone);
    return c;
  endfunction

  initial begin
    logic [IN_DATA_W-1:0] data;
    logic                 torque;
    cfg_t                 c;
    int                   ph, n, i;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed ticks under the reset settings.
    offer_tick(flat_tick(0, 0), 1'b0);           // new goal below limits, position below
    offer_tick(flat_tick(4095, 65535), 1'b0);    // goal and position above limits
    offer_tick(flat_tick(3000, 4000), 1'b1);     // tracking, saturates negative
    offer_tick(flat_tick(3000, 4000), 1'b0);     // torque released
    offer_tick(flat_tick(2500, 4000), 1'b1);     // enable from idle holds position
    offer_tick(flat_tick(2501, 2500), 1'b1);     // inside dead band
    offer_tick(flat_tick(2502, 2500), 1'b1);     // just past dead band
    offer_tick(flat_tick(1000, 2500), 1'b1);     // large error
    offer_tick(flat_tick(2500, 2500), 1'b1);     // inside arrival zone
    offer_tick(flat_tick(2500, 16'h1000 | 2500), 1'b1); // differs only above bit 11
    data = flat_tick(0, 4000);
    for (i = 0; i < NUM_SAMPLES; i++)
      data[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(101 * ((i * 7) % 10));
    offer_tick(data, 1'b1);                      // distinct samples, odd middle sum
    data = flat_tick(1000, 4000);
    for (i = 0; i < NUM_SAMPLES; i += 2) data[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(3001);
    offer_tick(data, 1'b1);                      // two clusters
    offer_tick(flat_tick(200, 200), 1'b1);       // position on lower limit
    offer_tick(flat_tick(4000, 4000), 1'b1);     // position on upper limit
    offer_tick(flat_tick(3900, 4000), 1'b0);     // release while away from goal
    offer_tick(flat_tick(3900, 4000), 1'b0);
    offer_tick(flat_tick(4095, 12), 1'b1);       // new goal while idle

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: c = make_settings(255, 255, 255, 0, 4095, 3600, 0, 0);
        1: c = make_settings(0, 0, 0, 4095, 0, 0, 3600, 4095);     // crossed limits
        2: c = make_settings(255, 0, 0, 0, 4095, 3600, 3600, 0);
        PHASES - 1: c = make_settings(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET,
                                      LOWER_LIMIT_RESET, UPPER_LIMIT_RESET,
                                      DRIVE_CEILING_RESET, DRIVE_FLOOR_RESET,
                                      ARRIVAL_ZONE_RESET);
        default: c = make_settings($urandom_range(8), $urandom_range(4), $urandom_range(6),
                                   $urandom_range(1000), $urandom_range(3000, 4095),
                                   $urandom_range(500, 3600), $urandom_range(200),
                                   $urandom_range(20));
      endcase
      load_settings(c);
      calm = (ph == 3);
      for (n = 0; n < TICKS_PER_PHASE; n++) begin
        // hold the sender once until every result is back
        if (ph == 4 && n == 70) wait_drained();
        random_tick(data, torque);
        offer_tick(data, torque);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
